/* hw/rtl/lms_pkg.sv */
// shared constants, step codes and pin bundle type for the led matrix scan serializer
package lms_pkg;

    // default geometry
    localparam int PHASES_DEF      = 36;
    localparam int COLUMNS_DEF     = 12;
    localparam int STORE_BYTES_DEF = 54;

    // port widths fixed by the item format
    localparam int ADDR_W  = 6;
    localparam int DATA_W  = 8;
    localparam int DWELL_W = 16;
    localparam int PHASE_W = 6;

    // dwell register value after reset
    localparam logic [DWELL_W-1:0] DWELL_RESET = 16'hA0;

    // sequencer step codes
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] ST_START_CLEAR = 4'd0;
    localparam logic [STEP_W-1:0] ST_START_LATCH = 4'd1;
    localparam logic [STEP_W-1:0] ST_COL_SETUP   = 4'd2;
    localparam logic [STEP_W-1:0] ST_COL_SHIFT   = 4'd3;
    localparam logic [STEP_W-1:0] ST_ROW_SHIFT   = 4'd4;
    localparam logic [STEP_W-1:0] ST_COL_LATCH   = 4'd5;
    localparam logic [STEP_W-1:0] ST_ENABLE      = 4'd6;
    localparam logic [STEP_W-1:0] ST_DWELL       = 4'd7;
    localparam logic [STEP_W-1:0] ST_END_CLEAR   = 4'd8;
    localparam logic [STEP_W-1:0] ST_END_LATCH   = 4'd9;

    // pin levels of one tick, minus the column data bit that comes from the store
    typedef struct packed {
        logic               col_active;
        logic               col_shift_clk;
        logic               col_latch_clk;
        logic               col_clear_n;
        logic               row_data;
        logic               row_shift_clk;
        logic               row_latch_clk;
        logic               row_clear_n;
        logic               row_enable_n;
        logic [PHASE_W-1:0] phase_index;
        logic               frame_done;
    } t_pins;

endpackage

/* hw/rtl/led_matrix_scan_serializer.sv */
// top level of the led matrix scan serializer: frame store, sequencer and result pipeline
//
// channel   direction  handshake                    payload
// in        input      i_in_valid / o_in_ready      i_cmd, i_write_address, i_write_data
// out       output     o_out_valid / i_out_ready    o_col_data .. o_frame_done
// cfg       input      i_cfg_we                     i_cfg_wdata (dwell ticks)
//
// one item is accepted per cycle while the output is not stalled; a tick result passes through
// the store read register, then the output register, a write item gives no result
// the sequencer advances in the accept cycle, so ticks run back to back
// reset clears the store through per-byte valid bits, no clearing pass is needed
// a stalled output holds the result pipeline; one more tick fits in the read stage,
// after that new items wait until the output drains
module led_matrix_scan_serializer #(
    parameter int PHASES      = lms_pkg::PHASES_DEF,
    parameter int COLUMNS     = lms_pkg::COLUMNS_DEF,
    parameter int STORE_BYTES = lms_pkg::STORE_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_cmd,
    input  logic [lms_pkg::ADDR_W-1:0]    i_write_address,
    input  logic [lms_pkg::DATA_W-1:0]    i_write_data,
    input  logic                          i_cfg_we,
    input  logic [lms_pkg::DWELL_W-1:0]   i_cfg_wdata,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_col_data,
    output logic                          o_col_shift_clk,
    output logic                          o_col_latch_clk,
    output logic                          o_col_clear_n,
    output logic                          o_row_data,
    output logic                          o_row_shift_clk,
    output logic                          o_row_latch_clk,
    output logic                          o_row_clear_n,
    output logic                          o_row_enable_n,
    output logic [lms_pkg::PHASE_W-1:0]   o_phase_index,
    output logic                          o_frame_done
);

    localparam int AW  = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int SBW = 9;

    logic [lms_pkg::DWELL_W-1:0] r_dwell;
    logic [STORE_BYTES-1:0]      r_valid;

    logic                        acc, acc_tick, acc_wr, wr_ok, s1_go;
    logic [AW-1:0]               wr_addr;

    lms_pkg::t_pins              seq_pins;
    logic [AW-1:0]               rd_addr;
    logic [2:0]                  rd_bit;
    logic                        rd_in_range;
    logic [lms_pkg::DATA_W-1:0]  ram_q;

    logic                        r_s1_vld;
    lms_pkg::t_pins              r_s1_pins;
    logic [2:0]                  r_s1_bit;
    logic                        r_s1_hit;

    logic                        r_o_vld;
    lms_pkg::t_pins              r_o_pins;
    logic                        r_o_col;

    // handshake
    assign s1_go      = !r_o_vld || i_out_ready;
    assign o_in_ready = !r_s1_vld || s1_go;
    assign acc        = i_in_valid && o_in_ready;
    assign acc_tick   = acc && !i_cmd;
    assign acc_wr     = acc && i_cmd;
    assign wr_addr    = AW'(i_write_address);
    assign wr_ok      = acc_wr && (SBW'(i_write_address) < SBW'(STORE_BYTES));

    // dwell register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dwell <= lms_pkg::DWELL_RESET;
        end else if (i_cfg_we) begin
            r_dwell <= i_cfg_wdata;
        end
    end

    // per-byte written flags, an unwritten byte reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_ok) begin
            r_valid[wr_addr] <= 1'b1;
        end
    end

    // frame store
    lms_ram #(
        .WIDTH (lms_pkg::DATA_W),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_ok),
        .i_waddr (wr_addr),
        .i_wdata (i_write_data),
        .i_re    (acc_tick),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // sequencer
    lms_seq #(
        .PHASES      (PHASES),
        .COLUMNS     (COLUMNS),
        .STORE_BYTES (STORE_BYTES)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (acc_tick),
        .i_dwell_ticks (r_dwell),
        .o_pins        (seq_pins),
        .o_rd_addr     (rd_addr),
        .o_rd_bit      (rd_bit),
        .o_rd_in_range (rd_in_range)
    );

    // read stage: pin levels wait here for the store data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (!r_s1_vld || s1_go) begin
            r_s1_vld <= acc_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_tick) begin
            r_s1_pins <= seq_pins;
            r_s1_bit  <= rd_bit;
            r_s1_hit  <= rd_in_range && r_valid[rd_addr];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (s1_go) begin
            r_o_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_vld) begin
            r_o_pins <= r_s1_pins;
            r_o_col  <= r_s1_pins.col_active && r_s1_hit && ram_q[r_s1_bit];
        end
    end

    assign o_out_valid     = r_o_vld;
    assign o_col_data      = r_o_col;
    assign o_col_shift_clk = r_o_pins.col_shift_clk;
    assign o_col_latch_clk = r_o_pins.col_latch_clk;
    assign o_col_clear_n   = r_o_pins.col_clear_n;
    assign o_row_data      = r_o_pins.row_data;
    assign o_row_shift_clk = r_o_pins.row_shift_clk;
    assign o_row_latch_clk = r_o_pins.row_latch_clk;
    assign o_row_clear_n   = r_o_pins.row_clear_n;
    assign o_row_enable_n  = r_o_pins.row_enable_n;
    assign o_phase_index   = r_o_pins.phase_index;
    assign o_frame_done    = r_o_pins.frame_done;

`ifndef ASSERT_OFF
    // a write item never leaves anything in the read stage
    a_wr_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_wr |=> !r_s1_vld)
        else $error("write item produced a result");

    // no item enters while the read stage is stalled, so the store data holds
    a_stall_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !s1_go) |-> !o_in_ready)
        else $error("item accepted over a stalled read stage");

    // column data only while the column chain is being fed
    a_col_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_col_data) |-> (o_row_enable_n && o_col_clear_n && !o_frame_done))
        else $error("column data outside the shift steps");

    // drivers are enabled only with both chains out of clear
    a_enable_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_row_enable_n) |-> (o_col_clear_n && o_row_clear_n))
        else $error("drivers enabled during clear");
`endif

endmodule

/* hw/rtl/lms_ram.sv */
// generic single-write, single-read ram with registered read data
module lms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/lms_seq.sv */
// scan sequencer: step, phase, bit and dwell counters, pin levels and store read address
module lms_seq #(
    parameter int PHASES      = lms_pkg::PHASES_DEF,
    parameter int COLUMNS     = lms_pkg::COLUMNS_DEF,
    parameter int STORE_BYTES = lms_pkg::STORE_BYTES_DEF,
    localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [lms_pkg::DWELL_W-1:0]   i_dwell_ticks,
    output lms_pkg::t_pins                o_pins,
    output logic [AW-1:0]                 o_rd_addr,
    output logic [2:0]                    o_rd_bit,
    output logic                          o_rd_in_range
);

    localparam int PW    = $clog2(PHASES);
    localparam int BW    = $clog2(COLUMNS + 1);
    localparam int NW_R  = $clog2(PHASES * COLUMNS);
    localparam int NW    = (NW_R < 4) ? 4 : NW_R;
    localparam int SBW   = 9;

    logic [lms_pkg::STEP_W-1:0]  r_step, n_step;
    logic [PW-1:0]               r_phase, n_phase;
    logic [BW-1:0]               r_bit, n_bit;
    logic [lms_pkg::DWELL_W-1:0] r_dwell_cnt, n_dwell_cnt;
    logic                        r_row_pend, n_row_pend;

    logic [lms_pkg::DWELL_W-1:0] dwell_inc;
    logic                        last_phase;
    logic [NW-1:0]               stream_idx;
    logic [NW-4:0]               byte_idx;
    lms_pkg::t_pins              pins;

    // stream bit position of the current column
    assign stream_idx    = NW'(r_phase) * NW'(COLUMNS) + NW'(r_bit);
    assign byte_idx      = stream_idx[NW-1:3];
    assign o_rd_bit      = stream_idx[2:0];
    assign o_rd_addr     = AW'(byte_idx);
    assign o_rd_in_range = (SBW'(byte_idx) < SBW'(STORE_BYTES));

    assign dwell_inc  = r_dwell_cnt + 1'b1;
    assign last_phase = (r_phase == PW'(PHASES - 1));

    // next state and pin levels
    always_comb begin
        n_step      = r_step;
        n_phase     = r_phase;
        n_bit       = r_bit;
        n_dwell_cnt = r_dwell_cnt;
        n_row_pend  = r_row_pend;

        pins               = '0;
        pins.col_clear_n   = 1'b1;
        pins.row_clear_n   = 1'b1;
        pins.row_enable_n  = 1'b1;

        case (r_step)
            lms_pkg::ST_START_LATCH: begin
                pins.col_latch_clk = 1'b1;
                pins.row_latch_clk = 1'b1;
                n_phase     = '0;
                n_bit       = '0;
                n_dwell_cnt = '0;
                n_step      = lms_pkg::ST_COL_SETUP;
            end
            lms_pkg::ST_COL_SETUP: begin
                pins.col_active  = 1'b1;
                pins.row_data    = r_row_pend;
                pins.phase_index = lms_pkg::PHASE_W'(r_phase);
                n_step           = lms_pkg::ST_COL_SHIFT;
            end
            lms_pkg::ST_COL_SHIFT: begin
                pins.col_active    = 1'b1;
                pins.col_shift_clk = 1'b1;
                pins.row_data      = r_row_pend;
                pins.phase_index   = lms_pkg::PHASE_W'(r_phase);
                n_bit              = r_bit + 1'b1;
                if (r_bit == BW'(COLUMNS - 1)) begin
                    n_step = lms_pkg::ST_ROW_SHIFT;
                end else begin
                    n_step = lms_pkg::ST_COL_SETUP;
                end
            end
            lms_pkg::ST_ROW_SHIFT: begin
                pins.row_data      = r_row_pend;
                pins.row_shift_clk = 1'b1;
                pins.row_latch_clk = 1'b1;
                pins.phase_index   = lms_pkg::PHASE_W'(r_phase);
                n_step             = lms_pkg::ST_COL_LATCH;
            end
            lms_pkg::ST_COL_LATCH: begin
                pins.col_latch_clk = 1'b1;
                pins.row_data      = r_row_pend;
                pins.phase_index   = lms_pkg::PHASE_W'(r_phase);
                n_step             = lms_pkg::ST_ENABLE;
            end
            lms_pkg::ST_ENABLE: begin
                pins.row_data     = r_row_pend;
                pins.row_enable_n = 1'b0;
                pins.phase_index  = lms_pkg::PHASE_W'(r_phase);
                n_row_pend        = 1'b0;
                n_dwell_cnt       = '0;
                if (i_dwell_ticks == '0) begin
                    if (last_phase) begin
                        n_phase = '0;
                        n_step  = lms_pkg::ST_END_CLEAR;
                    end else begin
                        n_phase = r_phase + 1'b1;
                        n_bit   = '0;
                        n_step  = lms_pkg::ST_COL_SETUP;
                    end
                end else begin
                    n_step = lms_pkg::ST_DWELL;
                end
            end
            lms_pkg::ST_DWELL: begin
                pins.row_enable_n = 1'b0;
                pins.phase_index  = lms_pkg::PHASE_W'(r_phase);
                n_dwell_cnt       = dwell_inc;
                // done when the count reaches the dwell or wraps around
                if ((dwell_inc >= i_dwell_ticks) || (dwell_inc == '0)) begin
                    n_dwell_cnt = '0;
                    if (last_phase) begin
                        n_phase = '0;
                        n_step  = lms_pkg::ST_END_CLEAR;
                    end else begin
                        n_phase = r_phase + 1'b1;
                        n_bit   = '0;
                        n_step  = lms_pkg::ST_COL_SETUP;
                    end
                end
            end
            lms_pkg::ST_END_CLEAR: begin
                pins.col_clear_n = 1'b0;
                pins.row_clear_n = 1'b0;
                n_row_pend       = 1'b1;
                n_step           = lms_pkg::ST_END_LATCH;
            end
            lms_pkg::ST_END_LATCH: begin
                pins.col_latch_clk = 1'b1;
                pins.row_latch_clk = 1'b1;
                pins.frame_done    = 1'b1;
                n_step             = lms_pkg::ST_START_CLEAR;
            end
            default: begin
                // start clear, and any unused code
                pins.col_clear_n = 1'b0;
                pins.row_clear_n = 1'b0;
                n_phase          = '0;
                n_bit            = '0;
                n_dwell_cnt      = '0;
                n_step           = lms_pkg::ST_START_LATCH;
            end
        endcase
    end

    assign o_pins = pins;

    // state registers, advance once per tick item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= lms_pkg::ST_START_CLEAR;
            r_phase     <= '0;
            r_bit       <= '0;
            r_dwell_cnt <= '0;
            r_row_pend  <= 1'b1;
        end else if (i_step) begin
            r_step      <= n_step;
            r_phase     <= n_phase;
            r_bit       <= n_bit;
            r_dwell_cnt <= n_dwell_cnt;
            r_row_pend  <= n_row_pend;
        end
    end

`ifndef ASSERT_OFF
    // column counter stays inside the chain while shifting
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == lms_pkg::ST_COL_SETUP || r_step == lms_pkg::ST_COL_SHIFT)
        |-> (r_bit < BW'(COLUMNS)))
        else $error("column counter past chain length");

    // the one-hot row bit is only pending before the first enable of a frame
    a_row_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_step == lms_pkg::ST_DWELL) |=> !r_row_pend)
        else $error("row bit pending after enable");

    // phase counter stays below the phase count
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PW'(PHASES - 1))
        else $error("phase counter out of range");
`endif

endmodule
